@@ rtl/rv64de_pkg.sv @@
// ----------------------------------------------------------------------------
// rv64de_pkg
// Shared types and encodings for the RV64I decode and execute stage.
// ----------------------------------------------------------------------------
package rv64de_pkg;

   // major opcodes
   localparam logic [6:0] OPC_LUI    = 7'h37;
   localparam logic [6:0] OPC_AUIPC  = 7'h17;
   localparam logic [6:0] OPC_JAL    = 7'h6f;
   localparam logic [6:0] OPC_JALR   = 7'h67;
   localparam logic [6:0] OPC_BRANCH = 7'h63;
   localparam logic [6:0] OPC_LOAD   = 7'h03;
   localparam logic [6:0] OPC_STORE  = 7'h23;
   localparam logic [6:0] OPC_OPIMM  = 7'h13;
   localparam logic [6:0] OPC_OP     = 7'h33;
   localparam logic [6:0] OPC_OPIMMW = 7'h1b;
   localparam logic [6:0] OPC_OPW    = 7'h3b;
   localparam logic [6:0] OPC_SYSTEM = 7'h73;

   localparam logic [31:0] ECALL_WORD = 32'h0000_0073;

   // alu funct3
   localparam logic [2:0] F3_ADD  = 3'd0;
   localparam logic [2:0] F3_SLL  = 3'd1;
   localparam logic [2:0] F3_SLT  = 3'd2;
   localparam logic [2:0] F3_SLTU = 3'd3;
   localparam logic [2:0] F3_XOR  = 3'd4;
   localparam logic [2:0] F3_SR   = 3'd5;
   localparam logic [2:0] F3_OR   = 3'd6;
   localparam logic [2:0] F3_AND  = 3'd7;

   // branch funct3
   localparam logic [2:0] F3_BEQ  = 3'd0;
   localparam logic [2:0] F3_BNE  = 3'd1;
   localparam logic [2:0] F3_BLT  = 3'd4;
   localparam logic [2:0] F3_BGE  = 3'd5;
   localparam logic [2:0] F3_BLTU = 3'd6;
   localparam logic [2:0] F3_BGEU = 3'd7;

   localparam logic [2:0] F3_JALR     = 3'd0;
   localparam logic [2:0] F3_LOAD_RSV = 3'd7;

   localparam logic [6:0] F7_BASE = 7'h00;
   localparam logic [6:0] F7_ALT  = 7'h20;

   localparam logic [1:0] MEM_NONE  = 2'd0;
   localparam logic [1:0] MEM_LOAD  = 2'd1;
   localparam logic [1:0] MEM_STORE = 2'd2;

   typedef struct packed {
      logic        [31:0] instr_word;
      logic        [63:0] inst_pc;
      logic signed [63:0] src1_value;
      logic signed [63:0] src2_value;
      logic               predicted_taken;
   } req_payload_type;

   typedef struct packed {
      logic signed [63:0] result_value;
      logic        [4:0]  dest_reg;
      logic               reg_write;
      logic        [1:0]  mem_op;
      logic        [1:0]  mem_size_log2;
      logic               load_unsigned;
      logic signed [63:0] store_data;
      logic               branch_taken;
      logic               redirect;
      logic        [63:0] redirect_pc;
      logic               is_syscall;
      logic               illegal;
   } rsp_payload_type;

endpackage

@@ rtl/rv64de_exec.sv @@
// ----------------------------------------------------------------------------
// rv64de_exec
// Decode, immediate extraction, alu, branch compare and redirect logic.
// ----------------------------------------------------------------------------
module rv64de_exec import rv64de_pkg::*; (
   input  req_payload_type req,
   output rsp_payload_type rsp
);

   logic [31:0] w;
   logic [6:0]  opc;
   logic [4:0]  rd;
   logic [2:0]  f3;
   logic [6:0]  f7;
   logic [63:0] a;
   logic [63:0] pc;

   logic [63:0] imm_i;
   logic [63:0] imm_s;
   logic [63:0] imm_b;
   logic [63:0] imm_u;

   logic [63:0] op_b;
   logic        alu_alt;
   logic [63:0] sum;
   logic [63:0] pc_plus4;
   logic [63:0] pc_add;
   logic        eq;
   logic        lt_s;
   logic        lt_u;
   logic [5:0]  sh64;
   logic [4:0]  sh32;
   logic [63:0] sll64;
   logic [63:0] srl64;
   logic [63:0] sra64;
   logic [31:0] sllw;
   logic [31:0] srlw;
   logic [31:0] sraw;
   logic [63:0] alu64;
   logic [63:0] aluw;

   logic        ill;
   logic        wr;
   logic        cond;
   logic [63:0] res;

   assign w   = req.instr_word;
   assign opc = w[6:0];
   assign rd  = w[11:7];
   assign f3  = w[14:12];
   assign f7  = w[31:25];
   assign a   = req.src1_value;
   assign pc  = req.inst_pc;

   assign imm_i = {{52{w[31]}}, w[31:20]};
   assign imm_s = {{52{w[31]}}, w[31:25], w[11:7]};
   assign imm_b = {{52{w[31]}}, w[7], w[30:25], w[11:8], 1'b0};
   assign imm_u = {{32{w[31]}}, w[31:12], 12'b0};

   always_comb begin
      case (opc)
         OPC_OPIMM, OPC_OPIMMW, OPC_LOAD, OPC_JALR: op_b = imm_i;
         OPC_STORE:                                 op_b = imm_s;
         default:                                   op_b = req.src2_value;
      endcase
   end

   // bit 30 selects sub or arithmetic shift; immediate forms only for shifts
   assign alu_alt = w[30] &&
                    (((opc == OPC_OPIMM || opc == OPC_OPIMMW) && f3 == F3_SR) ||
                     ((opc == OPC_OP || opc == OPC_OPW) && (f3 == F3_ADD || f3 == F3_SR)));

   assign sum      = alu_alt ? (a - op_b) : (a + op_b);
   assign pc_plus4 = pc + 64'd4;
   assign pc_add   = pc + ((opc == OPC_AUIPC) ? imm_u : imm_b);

   assign eq   = (a == op_b);
   assign lt_s = ($signed(a) < $signed(op_b));
   assign lt_u = (a < op_b);

   assign sh64  = op_b[5:0];
   assign sh32  = op_b[4:0];
   assign sll64 = a << sh64;
   assign srl64 = a >> sh64;
   assign sra64 = $signed(a) >>> sh64;
   assign sllw  = a[31:0] << sh32;
   assign srlw  = a[31:0] >> sh32;
   assign sraw  = $signed(a[31:0]) >>> sh32;

   always_comb begin
      case (f3)
         F3_ADD:  alu64 = sum;
         F3_SLL:  alu64 = sll64;
         F3_SLT:  alu64 = {63'b0, lt_s};
         F3_SLTU: alu64 = {63'b0, lt_u};
         F3_XOR:  alu64 = a ^ op_b;
         F3_SR:   alu64 = alu_alt ? sra64 : srl64;
         F3_OR:   alu64 = a | op_b;
         default: alu64 = a & op_b;
      endcase
   end

   always_comb begin
      case (f3)
         F3_ADD:  aluw = {{32{sum[31]}}, sum[31:0]};
         F3_SLL:  aluw = {{32{sllw[31]}}, sllw};
         default: aluw = alu_alt ? {{32{sraw[31]}}, sraw} : {{32{srlw[31]}}, srlw};
      endcase
   end

   always_comb begin
      ill  = 1'b0;
      wr   = 1'b0;
      cond = 1'b0;
      res  = '0;
      rsp  = '0;
      case (opc)
         OPC_LUI: begin
            res = imm_u;
            wr  = 1'b1;
         end
         OPC_AUIPC: begin
            res = pc_add;
            wr  = 1'b1;
         end
         OPC_JAL: begin
            res = pc_plus4;
            wr  = 1'b1;
         end
         OPC_JALR: begin
            if (f3 != F3_JALR) begin
               ill = 1'b1;
            end else begin
               res              = pc_plus4;
               wr               = 1'b1;
               rsp.redirect     = 1'b1;
               rsp.redirect_pc  = {sum[63:1], 1'b0};
            end
         end
         OPC_BRANCH: begin
            case (f3)
               F3_BEQ:  cond = eq;
               F3_BNE:  cond = !eq;
               F3_BLT:  cond = lt_s;
               F3_BGE:  cond = !lt_s;
               F3_BLTU: cond = lt_u;
               F3_BGEU: cond = !lt_u;
               default: ill  = 1'b1;
            endcase
            res              = {63'b0, cond};
            rsp.branch_taken = cond;
            if (cond != req.predicted_taken) begin
               rsp.redirect    = 1'b1;
               rsp.redirect_pc = cond ? pc_add : pc_plus4;
            end
         end
         OPC_LOAD: begin
            if (f3 == F3_LOAD_RSV) begin
               ill = 1'b1;
            end else begin
               res               = sum;
               wr                = 1'b1;
               rsp.mem_op        = MEM_LOAD;
               rsp.mem_size_log2 = f3[1:0];
               rsp.load_unsigned = f3[2];
            end
         end
         OPC_STORE: begin
            if (f3[2]) begin
               ill = 1'b1;
            end else begin
               res               = sum;
               rsp.mem_op        = MEM_STORE;
               rsp.mem_size_log2 = f3[1:0];
               rsp.store_data    = req.src2_value;
            end
         end
         OPC_OPIMM: begin
            if ((f3 == F3_SLL && w[31:26] != 6'd0) ||
                (f3 == F3_SR && {w[31], w[29:26]} != 5'd0)) begin
               ill = 1'b1;
            end else begin
               res = alu64;
               wr  = 1'b1;
            end
         end
         OPC_OP: begin
            if (f7 == F7_BASE || (f7 == F7_ALT && (f3 == F3_ADD || f3 == F3_SR))) begin
               res = alu64;
               wr  = 1'b1;
            end else begin
               ill = 1'b1;
            end
         end
         OPC_OPIMMW: begin
            if (f3 == F3_ADD || (f3 == F3_SLL && f7 == F7_BASE) ||
                (f3 == F3_SR && (f7 == F7_BASE || f7 == F7_ALT))) begin
               res = aluw;
               wr  = 1'b1;
            end else begin
               ill = 1'b1;
            end
         end
         OPC_OPW: begin
            if ((f3 == F3_ADD || f3 == F3_SLL || f3 == F3_SR) &&
                (f7 == F7_BASE || (f7 == F7_ALT && f3 != F3_SLL))) begin
               res = aluw;
               wr  = 1'b1;
            end else begin
               ill = 1'b1;
            end
         end
         OPC_SYSTEM: begin
            if (w != ECALL_WORD) begin
               ill = 1'b1;
            end else begin
               rsp.is_syscall = 1'b1;
            end
         end
         default: begin
            ill = 1'b1;
         end
      endcase

      rsp.result_value = res;
      rsp.dest_reg     = wr ? rd : 5'd0;
      rsp.reg_write    = wr && (rd != 5'd0);

      // an illegal instruction reports nothing but the flag
      if (ill) begin
         rsp         = '0;
         rsp.illegal = 1'b1;
      end
   end

endmodule

@@ rtl/rv64i_decode_execute_core.sv @@
// ----------------------------------------------------------------------------
// rv64i_decode_execute_core
// RV64I decode and execute stage with registered input and result.
// Path: an accepted request is held in the input register, then in the result register.
// Throughput: one instruction per cycle while the response side is not stalled; the decode and alu logic sits
// between the input register and the result register.
// Reset: synchronous; both pipeline valid bits clear, payloads are not reset.
// ----------------------------------------------------------------------------
module rv64i_decode_execute_core import rv64de_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  req_payload_type req_data,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_payload_type rsp_data
);

   logic            req_valid_ff;
   logic            req_valid_in;
   req_payload_type req_data_ff;
   logic            rsp_valid_ff;
   logic            rsp_valid_in;
   rsp_payload_type rsp_data_ff;
   rsp_payload_type rsp_data_in;
   logic            advance;
   logic            req_load;

   // the result register can take a new transaction when empty or draining
   assign advance      = !rsp_valid_ff || !rsp_stall;
   assign req_load     = !req_valid_ff || advance;
   assign req_stall    = !req_load;
   assign req_valid_in = req_load ? req_valid : req_valid_ff;
   assign rsp_valid_in = advance ? req_valid_ff : rsp_valid_ff;

   rv64de_exec u_exec (
      .req (req_data_ff),
      .rsp (rsp_data_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_load && req_valid) begin
         req_data_ff <= req_data;
      end
      if (advance && req_valid_ff) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

@@ rtl/rv64de_checker.sv @@
// ----------------------------------------------------------------------------
// rv64de_checker
// Port-level checks on the decode and execute stage, bound to the top level.
// ----------------------------------------------------------------------------
module rv64de_checker import rv64de_pkg::*; (
   input logic            clock,
   input logic            reset,
   input logic            req_valid,
   input logic            req_stall,
   input req_payload_type req_data,
   input logic            rsp_valid,
   input logic            rsp_stall,
   input rsp_payload_type rsp_data
);

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response changed");

   // an accepted transaction passes the input register and reaches the response when the output drains
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) ##1 !rsp_stall |=> rsp_valid)
      else $error("accepted transaction did not reach the response");

   a_illegal_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.illegal |-> !rsp_data.reg_write &&
         rsp_data.mem_op == MEM_NONE && !rsp_data.redirect && !rsp_data.is_syscall)
      else $error("illegal instruction with side effects");

   a_redirect_pc: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.redirect |-> rsp_data.redirect_pc == 64'd0)
      else $error("redirect target without redirect");

   a_no_x0_write: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.reg_write |-> rsp_data.dest_reg != 5'd0)
      else $error("write to x0");

endmodule

bind rv64i_decode_execute_core rv64de_checker u_checker (.*);

@@ verif/rv64de_execute_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rv64de_execute_checker
// Watches both channels of the decode and execute stage. Every accepted
// instruction is decoded and executed here to give the expected result,
// which is held in order and compared field by field with each accepted
// response.
// ----------------------------------------------------------------------------
module rv64de_execute_checker import rv64de_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   input  logic            req_stall,
   input  req_payload_type req_data,
   input  logic            rsp_valid,
   input  logic            rsp_stall,
   input  rsp_payload_type rsp_data,
   output int              fail_count,
   output int              outstanding
);

   rsp_payload_type pending_results[$];
   int mismatches = 0;
   int pending_count = 0;

   assign fail_count  = mismatches;
   assign outstanding = pending_count;

   function automatic logic [63:0] alu64(input logic [2:0] f3, input logic alt,
                                         input logic [63:0] a, input logic [63:0] b);
      logic signed [63:0] sa;
      logic [63:0] r;
      sa = a;
      case (f3)
         F3_ADD: begin
            if (alt) r = a - b;
            else r = a + b;
         end
         F3_SLL:  r = a << b[5:0];
         F3_SLT:  r = {63'b0, ($signed(a) < $signed(b))};
         F3_SLTU: r = {63'b0, (a < b)};
         F3_XOR:  r = a ^ b;
         F3_SR: begin
            if (alt) r = sa >>> b[5:0];
            else r = a >> b[5:0];
         end
         F3_OR:   r = a | b;
         default: r = a & b;
      endcase
      return r;
   endfunction

   // word forms: 32-bit operation, 5-bit shift amount, sign-extended result
   function automatic logic [63:0] alu32(input logic [2:0] f3, input logic alt,
                                         input logic [63:0] a, input logic [63:0] b);
      logic signed [31:0] sa;
      logic [31:0] lo;
      sa = a[31:0];
      if (f3 == F3_ADD) begin
         if (alt) lo = a[31:0] - b[31:0];
         else lo = a[31:0] + b[31:0];
      end else if (f3 == F3_SLL) begin
         lo = a[31:0] << b[4:0];
      end else if (alt) begin
         lo = sa >>> b[4:0];
      end else begin
         lo = a[31:0] >> b[4:0];
      end
      return {{32{lo[31]}}, lo};
   endfunction

   function automatic rsp_payload_type decode_execute(input req_payload_type req);
      logic [31:0] w;
      logic [63:0] pc, a, b;
      logic [6:0]  opc, f7;
      logic [4:0]  rd;
      logic [2:0]  f3;
      logic        alt, cond, wr, ill, sys, rdir, lu;
      logic [1:0]  mop, msz;
      logic [63:0] imm_i, imm_s, imm_b, imm_u, res, rpc, sdata;
      rsp_payload_type out;
      w     = req.instr_word;
      pc    = req.inst_pc;
      a     = req.src1_value;
      b     = req.src2_value;
      opc   = w[6:0];
      rd    = w[11:7];
      f3    = w[14:12];
      f7    = w[31:25];
      alt   = w[30];
      imm_i = {{52{w[31]}}, w[31:20]};
      imm_s = {{52{w[31]}}, w[31:25], w[11:7]};
      imm_b = {{51{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
      imm_u = {{32{w[31]}}, w[31:12], 12'b0};
      cond  = 1'b0;
      wr    = 1'b0;
      ill   = 1'b0;
      sys   = 1'b0;
      rdir  = 1'b0;
      lu    = 1'b0;
      mop   = MEM_NONE;
      msz   = 2'd0;
      res   = '0;
      rpc   = '0;
      sdata = '0;
      case (opc)
         OPC_LUI: begin
            res = imm_u;
            wr  = 1'b1;
         end
         OPC_AUIPC: begin
            res = pc + imm_u;
            wr  = 1'b1;
         end
         OPC_JAL: begin
            res = pc + 64'd4;
            wr  = 1'b1;
         end
         OPC_JALR: begin
            if (f3 != F3_JALR) begin
               ill = 1'b1;
            end else begin
               res  = pc + 64'd4;
               wr   = 1'b1;
               rdir = 1'b1;
               rpc  = (a + imm_i) & ~64'd1;
            end
         end
         OPC_BRANCH: begin
            case (f3)
               F3_BEQ:  cond = (a == b);
               F3_BNE:  cond = (a != b);
               F3_BLT:  cond = ($signed(a) < $signed(b));
               F3_BGE:  cond = ($signed(a) >= $signed(b));
               F3_BLTU: cond = (a < b);
               F3_BGEU: cond = (a >= b);
               default: ill = 1'b1;
            endcase
            if (!ill) begin
               res = {63'b0, cond};
               // redirect only when fetch guessed wrong
               if (cond != req.predicted_taken) begin
                  rdir = 1'b1;
                  rpc  = cond ? pc + imm_b : pc + 64'd4;
               end
            end
         end
         OPC_LOAD: begin
            if (f3 == F3_LOAD_RSV) begin
               ill = 1'b1;
            end else begin
               res = a + imm_i;
               wr  = 1'b1;
               mop = MEM_LOAD;
               msz = f3[1:0];
               lu  = f3[2];
            end
         end
         OPC_STORE: begin
            if (f3[2]) begin
               ill = 1'b1;
            end else begin
               res   = a + imm_s;
               mop   = MEM_STORE;
               msz   = f3[1:0];
               sdata = b;
            end
         end
         OPC_OPIMM: begin
            // shift immediates: no bit above the shift amount may be set, except bit 30 for right shifts
            if ((f3 == F3_SLL && w[31:26] != 6'd0) ||
                (f3 == F3_SR && {w[31], w[29:26]} != 5'd0)) begin
               ill = 1'b1;
            end else begin
               res = alu64(f3, (f3 == F3_SR) && alt, a, imm_i);
               wr  = 1'b1;
            end
         end
         OPC_OP: begin
            if (f7 == F7_BASE || (f7 == F7_ALT && (f3 == F3_ADD || f3 == F3_SR))) begin
               res = alu64(f3, alt, a, b);
               wr  = 1'b1;
            end else begin
               ill = 1'b1;
            end
         end
         OPC_OPIMMW: begin
            if (f3 == F3_ADD) begin
               res = alu32(F3_ADD, 1'b0, a, imm_i);
               wr  = 1'b1;
            end else if ((f3 == F3_SLL && f7 == F7_BASE) ||
                         (f3 == F3_SR && (f7 == F7_BASE || f7 == F7_ALT))) begin
               res = alu32(f3, alt, a, {59'b0, w[24:20]});
               wr  = 1'b1;
            end else begin
               ill = 1'b1;
            end
         end
         OPC_OPW: begin
            if ((f3 == F3_ADD || f3 == F3_SLL || f3 == F3_SR) &&
                (f7 == F7_BASE || (f7 == F7_ALT && f3 != F3_SLL))) begin
               res = alu32(f3, alt, a, b);
               wr  = 1'b1;
            end else begin
               ill = 1'b1;
            end
         end
         OPC_SYSTEM: begin
            if (w == ECALL_WORD) sys = 1'b1;
            else ill = 1'b1;
         end
         default: ill = 1'b1;
      endcase
      out = '0;
      if (ill) begin
         out.illegal = 1'b1;
      end else begin
         out.result_value  = res;
         out.dest_reg      = wr ? rd : 5'd0;
         out.reg_write     = wr && (rd != 5'd0);
         out.mem_op        = mop;
         out.mem_size_log2 = msz;
         out.load_unsigned = lu;
         out.store_data    = sdata;
         out.branch_taken  = cond;
         out.redirect      = rdir;
         out.redirect_pc   = rdir ? rpc : 64'd0;
         out.is_syscall    = sys;
      end
      return out;
   endfunction

   task automatic compare_field(input string field_name, input logic [63:0] want,
                                input logic [63:0] got);
      if (got !== want) begin
         $error("%s: expected %h, actual %h", field_name, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      rsp_payload_type want;
      if (!reset) begin
         if (req_valid && !req_stall) pending_results.push_back(decode_execute(req_data));
         if (rsp_valid && !rsp_stall) begin
            if (pending_results.size() == 0) begin
               $error("response transaction with no instruction pending");
               mismatches++;
            end else begin
               want = pending_results.pop_front();
               compare_field("result_value", want.result_value, rsp_data.result_value);
               compare_field("dest_reg", 64'(want.dest_reg), 64'(rsp_data.dest_reg));
               compare_field("reg_write", 64'(want.reg_write), 64'(rsp_data.reg_write));
               compare_field("mem_op", 64'(want.mem_op), 64'(rsp_data.mem_op));
               compare_field("mem_size_log2", 64'(want.mem_size_log2),
                             64'(rsp_data.mem_size_log2));
               compare_field("load_unsigned", 64'(want.load_unsigned),
                             64'(rsp_data.load_unsigned));
               compare_field("store_data", want.store_data, rsp_data.store_data);
               compare_field("branch_taken", 64'(want.branch_taken),
                             64'(rsp_data.branch_taken));
               compare_field("redirect", 64'(want.redirect), 64'(rsp_data.redirect));
               compare_field("redirect_pc", want.redirect_pc, rsp_data.redirect_pc);
               compare_field("is_syscall", 64'(want.is_syscall), 64'(rsp_data.is_syscall));
               compare_field("illegal", 64'(want.illegal), 64'(rsp_data.illegal));
            end
         end
         pending_count = pending_results.size();
      end
   end

endmodule

@@ verif/tb_rv64i_decode_execute_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rv64i_decode_execute_core
// Drives the decode and execute stage with a directed set of corner-case
// instructions followed by random, mostly well-formed instructions, with
// random idle cycles on the request side and random stalls on the response
// side. The checker beside the block predicts and compares every response.
// ----------------------------------------------------------------------------
module tb_rv64i_decode_execute_core;
   import rv64de_pkg::*;

   localparam int RANDOM_INSTRS = 1400;
   localparam int CYCLE_LIMIT   = 200000;
   localparam int DRAIN_CYCLES  = 8;

   localparam logic [2:0]  F3_SD          = 3'd3;
   localparam logic [2:0]  F3_LB          = 3'd0;
   localparam logic [2:0]  F3_LWU         = 3'd6;
   localparam logic [2:0]  F3_BAD_BRANCH  = 3'd2;
   localparam logic [2:0]  F3_BAD_STORE   = 3'd4;
   localparam logic [6:0]  F7_MULDIV      = 7'h01;
   localparam logic [31:0] EBREAK_WORD    = 32'h0010_0073;
   localparam logic [63:0] MIN_S64        = 64'h8000_0000_0000_0000;
   localparam logic [63:0] MAX_S64        = 64'h7fff_ffff_ffff_ffff;

   logic            clock     = 1'b0;
   logic            reset     = 1'b1;
   logic            req_valid = 1'b0;
   logic            req_stall;
   req_payload_type req_data  = '0;
   logic            rsp_valid;
   logic            rsp_stall = 1'b0;
   rsp_payload_type rsp_data;
   logic            quiet     = 1'b0;
   int              cycle_count = 0;
   int              fail_count;
   int              outstanding;

   always #5 clock = ~clock;

   rv64i_decode_execute_core i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   rv64de_execute_checker i_checker (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      rsp_stall   <= !quiet && ($urandom_range(0, 99) < 24);
      if (cycle_count == CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   function automatic logic [31:0] enc_i(input logic [11:0] imm, input logic [2:0] f3,
                                         input logic [4:0] rd, input logic [6:0] opc);
      logic [31:0] r;
      r = $urandom;
      return {imm, r[4:0], f3, rd, opc};
   endfunction

   function automatic logic [31:0] enc_r(input logic [6:0] f7, input logic [2:0] f3,
                                         input logic [4:0] rd, input logic [6:0] opc);
      logic [31:0] r;
      r = $urandom;
      return {f7, r[9:5], r[4:0], f3, rd, opc};
   endfunction

   function automatic logic [31:0] enc_s(input logic [11:0] imm, input logic [2:0] f3);
      logic [31:0] r;
      r = $urandom;
      return {imm[11:5], r[9:5], r[4:0], f3, imm[4:0], OPC_STORE};
   endfunction

   function automatic logic [31:0] enc_b(input logic [12:0] imm, input logic [2:0] f3);
      logic [31:0] r;
      r = $urandom;
      return {imm[12], imm[10:5], r[9:5], r[4:0], f3, imm[4:1], imm[11], OPC_BRANCH};
   endfunction

   function automatic logic [31:0] enc_u(input logic [19:0] imm, input logic [4:0] rd,
                                         input logic [6:0] opc);
      return {imm, rd, opc};
   endfunction

   function automatic logic [63:0] random_operand();
      logic [31:0] r;
      r = $urandom;
      case ($urandom_range(0, 7))
         0: return '0;
         1: return '1;
         2: return MIN_S64;
         3: return MAX_S64;
         4: return 64'($urandom_range(0, 70));
         5: return {{32{r[31]}}, r};
         default: return {$urandom, $urandom};
      endcase
   endfunction

   function automatic logic [63:0] random_pc();
      case ($urandom_range(0, 7))
         0: return 64'hffff_ffff_ffff_fff0 | 64'($urandom_range(0, 15));
         1: return 64'($urandom_range(0, 4095));
         default: return {$urandom, $urandom};
      endcase
   endfunction

   // mostly legal encodings with random content, some broken ones and raw noise
   function automatic logic [31:0] random_instruction();
      logic [31:0] w;
      logic [6:0]  opc;
      logic [2:0]  f3;
      w = $urandom;
      if ($urandom_range(0, 19) == 0) return w;
      case ($urandom_range(0, 11))
         0:  opc = OPC_LUI;
         1:  opc = OPC_AUIPC;
         2:  opc = OPC_JAL;
         3:  opc = OPC_JALR;
         4:  opc = OPC_BRANCH;
         5:  opc = OPC_LOAD;
         6:  opc = OPC_STORE;
         7:  opc = OPC_OPIMM;
         8:  opc = OPC_OP;
         9:  opc = OPC_OPIMMW;
         10: opc = OPC_OPW;
         default: opc = OPC_SYSTEM;
      endcase
      w[6:0] = opc;
      if ($urandom_range(0, 9) == 0) return w;
      case (opc)
         OPC_JALR: w[14:12] = F3_JALR;
         OPC_BRANCH: begin
            f3 = 3'($urandom_range(2, 7));
            if (f3 < F3_BLT) f3 = f3 - 3'd2;
            w[14:12] = f3;
         end
         OPC_LOAD: w[14:12] = 3'($urandom_range(0, 6));
         OPC_STORE: w[14] = 1'b0;
         OPC_OPIMM: begin
            if (w[14:12] == F3_SLL) w[31:26] = 6'd0;
            if (w[14:12] == F3_SR) begin
               w[31]    = 1'b0;
               w[29:26] = 4'd0;
            end
         end
         OPC_OP: begin
            w[31:25] = F7_BASE;
            if ((w[14:12] == F3_ADD || w[14:12] == F3_SR) && $urandom_range(0, 1))
               w[31:25] = F7_ALT;
         end
         OPC_OPIMMW, OPC_OPW: begin
            case ($urandom_range(0, 2))
               0: f3 = F3_ADD;
               1: f3 = F3_SLL;
               default: f3 = F3_SR;
            endcase
            w[14:12] = f3;
            if (opc == OPC_OPW || f3 != F3_ADD) begin
               w[31:25] = F7_BASE;
               if (f3 != F3_SLL && $urandom_range(0, 1)) w[31:25] = F7_ALT;
            end
         end
         OPC_SYSTEM: w = ECALL_WORD;
         default: ;
      endcase
      return w;
   endfunction

   task automatic send_instr(input logic [31:0] word, input logic [63:0] pc,
                             input logic [63:0] a, input logic [63:0] b,
                             input logic pred);
      req_payload_type item;
      item.instr_word      = word;
      item.inst_pc         = pc;
      item.src1_value      = a;
      item.src2_value      = b;
      item.predicted_taken = pred;
      // each idle cycle is a separate draw
      while (!quiet && $urandom_range(0, 99) < 24) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   initial begin
      logic [63:0] a;
      logic [63:0] b;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // upper immediates, jumps
      send_instr(enc_u(20'hfffff, 5'd5, OPC_LUI), random_pc(), '1, '1, 1'b0);
      send_instr(enc_u(20'h80000, 5'd31, OPC_AUIPC), '1, '0, '0, 1'b1);
      send_instr(enc_u(20'hfffff, 5'd1, OPC_JAL), 64'hffff_ffff_ffff_fffc, '0, '0, 1'b0);
      // jalr to x0 with an odd target
      send_instr(enc_i(12'hfff, F3_JALR, 5'd0, OPC_JALR), random_pc(), 64'd2, '1, 1'b0);
      send_instr(enc_i(12'h004, F3_SLL, 5'd3, OPC_JALR), random_pc(), '1, '1, 1'b1);
      // branches, both kinds of misprediction
      send_instr(enc_b(13'h1000, F3_BEQ), random_pc(), MIN_S64, MIN_S64, 1'b0);
      send_instr(enc_b(13'h1ff0, F3_BGE), random_pc(), MIN_S64, MAX_S64, 1'b1);
      send_instr(enc_b(13'h0008, F3_BLTU), random_pc(), MAX_S64, MIN_S64, 1'b0);
      send_instr(enc_b(13'h0ffe, F3_BGEU), '1, '0, '1, 1'b1);
      send_instr(enc_b(13'h0004, F3_BAD_BRANCH), random_pc(), '0, '0, 1'b1);
      // loads and stores
      send_instr(enc_i(12'h800, F3_LB, 5'd7, OPC_LOAD), random_pc(), '0, '1, 1'b0);
      send_instr(enc_i(12'h7ff, F3_LWU, 5'd8, OPC_LOAD), random_pc(), '1, '0, 1'b0);
      send_instr(enc_i(12'h000, F3_LOAD_RSV, 5'd8, OPC_LOAD), random_pc(), '1, '0, 1'b0);
      send_instr(enc_s(12'hfff, F3_SD), random_pc(), MAX_S64, MIN_S64, 1'b0);
      send_instr(enc_s(12'h000, F3_BAD_STORE), random_pc(), MAX_S64, MIN_S64, 1'b0);
      // shift immediates: legal arithmetic select and a stray upper bit
      send_instr(enc_i({6'b010000, 6'd63}, F3_SR, 5'd9, OPC_OPIMM), random_pc(),
                 MIN_S64, '0, 1'b0);
      send_instr(enc_i({6'b100000, 6'd1}, F3_SLL, 5'd9, OPC_OPIMM), random_pc(),
                 MIN_S64, '0, 1'b0);
      // register forms, including the multiply encoding
      send_instr(enc_r(F7_ALT, F3_ADD, 5'd10, OPC_OP), random_pc(), MIN_S64, 64'd1, 1'b0);
      send_instr(enc_r(F7_MULDIV, F3_ADD, 5'd10, OPC_OP), random_pc(), '1, '1, 1'b0);
      // word forms
      send_instr(enc_i({7'h20, 5'd31}, F3_SR, 5'd11, OPC_OPIMMW), random_pc(),
                 64'h0000_0000_8000_0000, '0, 1'b0);
      send_instr(enc_r(F7_ALT, F3_ADD, 5'd12, OPC_OPW), random_pc(), '0, 64'd1, 1'b0);
      send_instr(enc_r(F7_ALT, F3_SR, 5'd12, OPC_OPW), random_pc(),
                 64'h0000_0000_8000_0001, 64'd63, 1'b0);
      send_instr(enc_r(F7_BASE, F3_SLT, 5'd12, OPC_OPW), random_pc(), '1, '1, 1'b0);
      // system words and an all-zero word
      send_instr(ECALL_WORD, random_pc(), '1, '1, 1'b1);
      send_instr(EBREAK_WORD, random_pc(), '1, '1, 1'b1);
      send_instr(32'h0000_0000, random_pc(), '1, '1, 1'b1);

      for (int i = 0; i < RANDOM_INSTRS; i++) begin
         quiet = (i >= 600 && i < 900);
         a = random_operand();
         b = ($urandom_range(0, 2) == 0) ? a : random_operand();
         send_instr(random_instruction(), random_pc(), a, b, 1'($urandom_range(0, 1)));
      end
      quiet = 1'b0;
      req_valid <= 1'b0;

      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

@@ sim.f @@
rtl/rv64de_pkg.sv
rtl/rv64de_exec.sv
rtl/rv64i_decode_execute_core.sv
rtl/rv64de_checker.sv
verif/rv64de_execute_checker.sv
verif/tb_rv64i_decode_execute_core.sv
